// ===== src/fps_pkg.sv =====
// Shared types and constants of the funnel path smoother.
// Used by the top level, the cross product unit and the port checker.
package fps_pkg;

    localparam int MAX_PORTALS = 64;
    localparam int COORD_BITS  = 16;
    localparam int MAX_RESULTS = 64;

    localparam int IDX_W = $clog2(MAX_PORTALS);
    localparam int CNT_W = $clog2(MAX_PORTALS + 1);
    localparam int RES_W = $clog2(MAX_RESULTS);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int AREA_W = PROD_W + 1;

    localparam int PORTAL_W  = 4 * COORD_BITS;
    localparam int POINT_W   = 2 * COORD_BITS;
    localparam int S_TDATA_W = ((PORTAL_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((POINT_W + 7) / 8) * 8;

    localparam logic [RES_W-1:0] CORNER_LIMIT = RES_W'(MAX_RESULTS - 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic signed [AREA_W-1:0] area_t;

    // x sits in the low bits of a point, the left point in the low bits of a portal.
    typedef struct packed {
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
    } point_t;

    typedef struct packed {
        point_t r;
        point_t l;
    } portal_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_RD,
        ST_INIT,
        ST_CHECK,
        ST_FETCH,
        ST_R1,
        ST_R2,
        ST_L1,
        ST_L2,
        ST_CORNER,
        ST_FINAL
    } state_t;

    typedef enum logic {
        SIDE_RIGHT,
        SIDE_LEFT
    } side_t;

endpackage

// ===== src/funnel_path_smoother_unit.sv =====
// Top level of the funnel path smoother: portal store, scan sequencer, output register.
// Depends on fps_pkg and on the shared cross product unit fps_area2.
//
// Usage: portals stream in on the s_axis channel, one item per portal, with the
// left point in the low half of tdata and the right point above it. tlast marks
// the final portal of a chain. Each non-final item is stored while the store has room,
// and the block is ready again in the next cycle. The final item starts the funnel
// scan, during which s_axis_tready stays low.
// Path corners leave on the m_axis channel, one item per point, x in the low
// bits of tdata; tlast marks the final point (the last portal's left point) and
// tuser flags a run in which portals beyond the store's capacity were dropped.
// Throughput: loading accepts one portal per cycle. The scan steps through the store
// with a single registered cross product unit and a read port of the store;
// each portal step runs a read, a fetch, one or two right-side tests and one or two
// left-side tests, and each corner passes through a state that loads the output
// register and restarts the walk just after the new apex. Before the first step,
// the first portal is read and the apex, left and right points are set from it.
// When the receiver stalls, the scan waits in front of the output register with
// all state held; the final result may stay pending while the next chain loads.
// Reset (aresetn low, synchronous) empties the store's fill count, clears the
// dropped flag and the output valid flag, and returns the sequencer to idle.
module funnel_path_smoother_unit
    import fps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata, from bit 0: left_x, left_y, right_x, right_y
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tdata, from bit 0: point_x, point_y
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast,
    // tuser, bit 0: overflow
    output logic                 m_axis_tuser
);

    state_t state_reg, state_next;

    // Portal store with one write port and one registered read port.
    portal_t store_mem [MAX_PORTALS];
    portal_t rd_data_reg;
    logic    mem_we, rd_en;
    idx_t    rd_addr;

    cnt_t       count_reg, count_next;
    logic       dropped_reg, dropped_next;
    cnt_t       i_reg, i_next;
    logic [RES_W-1:0] corners_reg, corners_next;

    point_t apex_reg, apex_next;
    point_t left_reg, left_next;
    point_t right_reg, right_next;
    idx_t   apex_idx_reg, apex_idx_next;
    idx_t   left_idx_reg, left_idx_next;
    idx_t   right_idx_reg, right_idx_next;

    logic   m_valid_reg, m_valid_next;
    point_t m_point_reg, m_point_next;
    logic   m_last_reg, m_last_next;
    logic   m_user_reg, m_user_next;

    portal_t s_portal;
    logic    s_accept;
    logic    out_free;
    logic    in_range;
    logic    same_ar, same_al;
    logic    corner_room;

    side_t  b_side;
    side_t  c_side;
    point_t op_b, op_c;
    area_t  area;
    logic   area_le0, area_lt0;

    assign s_portal  = portal_t'(s_axis_tdata[PORTAL_W-1:0]);
    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign in_range  = i_reg < count_reg;
    assign same_ar   = apex_reg == right_reg;
    assign same_al   = apex_reg == left_reg;
    assign corner_room = corners_reg != CORNER_LIMIT;

    // Operand selection for the shared unit: the apex is always the origin.
    assign op_b = (b_side == SIDE_LEFT) ? left_reg : right_reg;
    assign op_c = (c_side == SIDE_LEFT) ? rd_data_reg.l : rd_data_reg.r;

    fps_area2 u_area2 (
        .aclk (aclk),
        .a    (apex_reg),
        .b    (op_b),
        .c    (op_c),
        .area (area)
    );

    assign area_lt0 = area[AREA_W-1];
    assign area_le0 = area_lt0 || (area == '0);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[count_reg[IDX_W-1:0]] <= s_portal;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // Next state of the scan sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_axis_tlast) begin
                    state_next = ST_INIT_RD;
                end
            end
            ST_INIT_RD: state_next = ST_INIT;
            ST_INIT:    state_next = ST_CHECK;
            ST_CHECK:   state_next = in_range ? ST_FETCH : ST_FINAL;
            ST_FETCH:   state_next = ST_R1;
            ST_R1: begin
                state_next = (area_le0 && !same_ar) ? ST_R2 : ST_L1;
            end
            ST_R2: begin
                state_next = area_le0 ? ST_CORNER : ST_L1;
            end
            ST_L1: begin
                state_next = (!area_lt0 && !same_al) ? ST_L2 : ST_CHECK;
            end
            ST_L2: begin
                state_next = area_lt0 ? ST_CHECK : ST_CORNER;
            end
            ST_CORNER: begin
                if (!corner_room || out_free) begin
                    state_next = ST_CHECK;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath updates.
    always_comb begin
        s_axis_tready  = 1'b0;
        mem_we         = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        b_side         = SIDE_RIGHT;
        c_side         = SIDE_RIGHT;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        i_next         = i_reg;
        corners_next   = corners_reg;
        apex_next      = apex_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        apex_idx_next  = apex_idx_reg;
        left_idx_next  = left_idx_reg;
        right_idx_next = right_idx_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_point_next   = m_point_reg;
        m_last_next    = m_last_reg;
        m_user_next    = m_user_reg;

        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_accept) begin
                    if (count_reg < CNT_W'(MAX_PORTALS)) begin
                        mem_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
            end
            ST_INIT_RD: begin
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ST_INIT: begin
                apex_next      = rd_data_reg.l;
                left_next      = rd_data_reg.l;
                right_next     = rd_data_reg.r;
                apex_idx_next  = '0;
                left_idx_next  = '0;
                right_idx_next = '0;
                i_next         = CNT_W'(1);
                corners_next   = '0;
            end
            ST_CHECK: begin
                rd_en   = 1'b1;
                rd_addr = in_range ? i_reg[IDX_W-1:0] : IDX_W'(count_reg - 1'b1);
            end
            ST_FETCH: begin
                b_side = SIDE_RIGHT;
                c_side = SIDE_RIGHT;
            end
            ST_R1: begin
                b_side = SIDE_LEFT;
                c_side = SIDE_LEFT;
                if (area_le0) begin
                    if (same_ar) begin
                        right_next     = rd_data_reg.r;
                        right_idx_next = i_reg[IDX_W-1:0];
                    end else begin
                        c_side = SIDE_RIGHT;
                    end
                end
            end
            ST_R2: begin
                b_side = SIDE_LEFT;
                c_side = SIDE_LEFT;
                if (!area_le0) begin
                    right_next     = rd_data_reg.r;
                    right_idx_next = i_reg[IDX_W-1:0];
                end else begin
                    // Right side crosses the left one: the left point is a corner.
                    apex_next      = left_reg;
                    right_next     = left_reg;
                    apex_idx_next  = left_idx_reg;
                    right_idx_next = left_idx_reg;
                    i_next         = CNT_W'(left_idx_reg) + 1'b1;
                end
            end
            ST_L1: begin
                b_side = SIDE_RIGHT;
                c_side = SIDE_LEFT;
                if (!area_lt0) begin
                    if (same_al) begin
                        left_next     = rd_data_reg.l;
                        left_idx_next = i_reg[IDX_W-1:0];
                        i_next        = i_reg + 1'b1;
                    end
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_L2: begin
                if (area_lt0) begin
                    left_next     = rd_data_reg.l;
                    left_idx_next = i_reg[IDX_W-1:0];
                    i_next        = i_reg + 1'b1;
                end else begin
                    // Left side crosses the right one: the right point is a corner.
                    apex_next     = right_reg;
                    left_next     = right_reg;
                    apex_idx_next = right_idx_reg;
                    left_idx_next = right_idx_reg;
                    i_next        = CNT_W'(right_idx_reg) + 1'b1;
                end
            end
            ST_CORNER: begin
                if (corner_room && out_free) begin
                    m_valid_next = 1'b1;
                    m_point_next = apex_reg;
                    m_last_next  = 1'b0;
                    m_user_next  = dropped_reg;
                    corners_next = corners_reg + 1'b1;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_point_next = rd_data_reg.l;
                    m_last_next  = 1'b1;
                    m_user_next  = dropped_reg;
                    count_next   = '0;
                    dropped_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            i_reg         <= '0;
            corners_reg   <= '0;
            apex_idx_reg  <= '0;
            left_idx_reg  <= '0;
            right_idx_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            i_reg         <= i_next;
            corners_reg   <= corners_next;
            apex_idx_reg  <= apex_idx_next;
            left_idx_reg  <= left_idx_next;
            right_idx_reg <= right_idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        apex_reg    <= apex_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        m_point_reg <= m_point_next;
        m_last_reg  <= m_last_next;
        m_user_reg  <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_point_reg);
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

// ===== src/fps_area2.sv =====
// Shared doubled cross product unit: area2(a, b, c) with one register stage.
// Depends on fps_pkg for point and area types.
module fps_area2
    import fps_pkg::*;
(
    input  logic   aclk,
    input  point_t a,
    input  point_t b,
    input  point_t c,
    output area_t  area
);

    logic signed [DIFF_W-1:0] ax, ay, bx, by;
    logic signed [PROD_W-1:0] p1_reg, p2_reg;

    assign ax = $signed({1'b0, b.x}) - $signed({1'b0, a.x});
    assign ay = $signed({1'b0, b.y}) - $signed({1'b0, a.y});
    assign bx = $signed({1'b0, c.x}) - $signed({1'b0, a.x});
    assign by = $signed({1'b0, c.y}) - $signed({1'b0, a.y});

    always_ff @(posedge aclk) begin
        p1_reg <= bx * ay;
        p2_reg <= ax * by;
    end

    // The difference of the two products is exact one bit wider than a product.
    assign area = AREA_W'(p1_reg) - AREA_W'(p2_reg);

endmodule

// ===== src/fps_checker.sv =====
// Port-level checks of the funnel path smoother, bound to its top level.
// Depends on fps_pkg for the channel widths.
module fps_checker
    import fps_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 s_axis_tlast,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    // A stalled result item holds its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result item changed");

    // Reset leaves the block ready and with no result pending.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready && !m_axis_tvalid)
        else $error("block not idle after reset");

    // The final portal starts the scan, so the input closes right after it.
    a_scan_closes_input: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after final portal");

    // Corners only come out while a scan runs, never while portals load.
    a_corner_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("corner item pending while input open");

endmodule

bind funnel_path_smoother_unit fps_checker u_fps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
